@@ design/rgp_pkg.sv @@
`timescale 1ns / 1ps

package rgp_pkg;

  // Widths of the register fields and of the stream fields.
  localparam int DimW    = 13;
  localparam int CoordW  = 12;
  localparam int RadiusW = 12;
  localparam int ColorW  = 24;
  localparam int ChanW   = 8;
  localparam int NumCh   = 3;

  // Squared radius, squared distance and the blend numerator.
  localparam int R2W     = 2 * RadiusW;
  localparam int Dist2W  = 2 * CoordW + 1;
  localparam int NumW    = R2W + ChanW;

  // Largest canvas dimension; larger register values are saturated to it.
  localparam int MaxDim  = 4096;
  localparam int ClampW  = 17;

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = ColorW;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 3'd0,
    CfgImageHeight = 3'd1,
    CfgRadius      = 3'd2,
    CfgStartColor  = 3'd3,
    CfgFinalColor  = 3'd4
  } cfg_reg_e;

  // Reset values of the configuration registers.
  localparam logic [DimW-1:0]    ImageWidthRst  = 13'd640;
  localparam logic [DimW-1:0]    ImageHeightRst = 13'd480;
  localparam logic [RadiusW-1:0] RadiusRst      = 12'd384;
  localparam logic [ColorW-1:0]  StartColorRst  = 24'h004646;
  localparam logic [ColorW-1:0]  FinalColorRst  = 24'h000000;

  // Stream packing.
  localparam int InDataW  = 2 * CoordW;
  localparam int OutDataW = NumCh * ChanW;

  // Pipeline: offset, square, sum, products, numerator, then one stage per quotient bit.
  localparam int NumStages = 5 + ChanW;

  typedef logic [NumW-1:0]  num_t;
  typedef logic [ChanW-1:0] chan_t;

  // Saturate a dimension and halve it to give the center coordinate.
  function automatic logic [CoordW-1:0] center_of(input logic [DimW-1:0] dim);
    logic [ClampW-1:0] ext;
    logic [ClampW-1:0] lim;
    ext = ClampW'(dim);
    lim = (ext > ClampW'(MaxDim)) ? ClampW'(MaxDim) : ext;
    return lim[CoordW:1];
  endfunction

  // Pick one color channel; channel 0 is red in the top byte.
  function automatic chan_t chan_of(input logic [ColorW-1:0] rgb, input int k);
    return rgb[ColorW-1-ChanW*k -: ChanW];
  endfunction

endpackage

@@ design/radial_gradient_pixel_top.sv @@
`timescale 1ns / 1ps

// Radial gradient pixel colorer.
// The slave stream takes one pixel coordinate per transaction and the master
// stream returns its color for each one taken. Every input transaction gives
// exactly one output transaction, in order.
// The configuration channel writes image width, image height, radius, start
// color and final color by index; it is always ready. The user must write it
// only while no pixel is in flight; the block itself does not enforce this.
// A new radius takes effect after passing through radius_q and then big_r2_q.
// The pipeline runs offset, square, sum, two blend stages and eight restoring
// division stages, one quotient bit each, the last serving as output register.
// Throughput is one pixel per clock unless stalled; the whole pipeline advances together.
// When the receiver stalls with a result waiting, the pipeline holds and
// s_axis_tready drops in the same cycle; no result is lost or repeated.
// Reset clears all valid bits and loads the default configuration:
// 640 x 480, radius 384, start color (0,70,70), final color black.
module radial_gradient_pixel_top
  import rgp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Pixel coordinates in.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // pixel_x [11:0], pixel_y [23:12]
  // Pixel colors out.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic                m_axis_tuser    // inside_disk [0]
);

  localparam int DivBase = NumStages - ChanW - 1;

  // Configuration registers.
  logic [DimW-1:0]    image_width_q, image_height_q;
  logic [RadiusW-1:0] radius_q;
  logic [ColorW-1:0]  start_color_q, final_color_q;
  logic [R2W-1:0]     big_r2_q;

  // Pipeline control and payload.
  logic                 en;
  logic [NumStages-1:0] vld_q;
  logic [CoordW-1:0]    dx_q, dy_q;
  logic [R2W-1:0]       dxx_q, dyy_q;
  logic [Dist2W-1:0]    r2_q;
  logic                 ins_q [DivBase-1:NumStages-1];
  num_t                 pa_q [NumCh], pb_q [NumCh];
  num_t                 rem_q [ChanW+1][NumCh];
  chan_t                quo_q [ChanW+1][NumCh];

  logic [CoordW-1:0] xc, yc, px, py;
  logic [R2W-1:0]    r2_low;

  assign cfg_ready_o = 1'b1;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= ImageWidthRst;
      image_height_q <= ImageHeightRst;
      radius_q       <= RadiusRst;
      start_color_q  <= StartColorRst;
      final_color_q  <= FinalColorRst;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgImageWidth:  image_width_q  <= cfg_data_i[DimW-1:0];
        CfgImageHeight: image_height_q <= cfg_data_i[DimW-1:0];
        CfgRadius:      radius_q       <= cfg_data_i[RadiusW-1:0];
        CfgStartColor:  start_color_q  <= cfg_data_i[ColorW-1:0];
        CfgFinalColor:  final_color_q  <= cfg_data_i[ColorW-1:0];
        default: ;
      endcase
    end
  end

  // Squared radius follows the radius register in the next cycle.
  always_ff @(posedge clk_i) begin
    big_r2_q <= R2W'(radius_q) * R2W'(radius_q);
  end

  // The whole pipeline moves unless a finished result is held back.
  assign en            = !vld_q[NumStages-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], s_axis_tvalid};
    end
  end

  assign xc     = center_of(image_width_q);
  assign yc     = center_of(image_height_q);
  assign px     = s_axis_tdata[CoordW-1:0];
  assign py     = s_axis_tdata[2*CoordW-1:CoordW];
  assign r2_low = r2_q[R2W-1:0];

  // Distance, squares, sum, blend products and numerator.
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q  <= (px >= xc) ? px - xc : xc - px;
      dy_q  <= (py >= yc) ? py - yc : yc - py;
      dxx_q <= R2W'(dx_q) * R2W'(dx_q);
      dyy_q <= R2W'(dy_q) * R2W'(dy_q);
      r2_q  <= Dist2W'(dxx_q) + Dist2W'(dyy_q);
      ins_q[DivBase-1] <= r2_q < Dist2W'(big_r2_q);
      ins_q[DivBase]   <= ins_q[DivBase-1];
      for (int k = 0; k < NumCh; k++) begin
        // Outside the disk these products are discarded at the output.
        pa_q[k] <= NumW'(big_r2_q - r2_low) * NumW'(chan_of(final_color_q, k));
        pb_q[k] <= NumW'(r2_low) * NumW'(chan_of(start_color_q, k));
        rem_q[0][k] <= pa_q[k] + pb_q[k];
        quo_q[0][k] <= '0;
      end
      // Restoring division by the squared radius, most significant bit first.
      for (int j = 1; j <= ChanW; j++) begin
        ins_q[DivBase+j] <= ins_q[DivBase+j-1];
        for (int k = 0; k < NumCh; k++) begin
          if (rem_q[j-1][k] >= (NumW'(big_r2_q) << (ChanW - j))) begin
            rem_q[j][k] <= rem_q[j-1][k] - (NumW'(big_r2_q) << (ChanW - j));
            quo_q[j][k] <= quo_q[j-1][k] | (chan_t'(1) << (ChanW - j));
          end else begin
            rem_q[j][k] <= rem_q[j-1][k];
            quo_q[j][k] <= quo_q[j-1][k];
          end
        end
      end
    end
  end

  // Outside the disk the pixel takes the start color.
  always_comb begin
    for (int k = 0; k < NumCh; k++) begin
      m_axis_tdata[ChanW*k +: ChanW] = ins_q[NumStages-1] ? quo_q[ChanW][k]
                                                          : chan_of(start_color_q, k);
    end
  end

  assign m_axis_tuser  = ins_q[NumStages-1];
  assign m_axis_tvalid = vld_q[NumStages-1];

endmodule

@@ design/rgp_checker.sv @@
`timescale 1ns / 1ps

module rgp_checker
  import rgp_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  // A stalled result keeps its color and flag.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A receiver that takes results never holds back the input.
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready || !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output drains");

  // A new result only shows up after the pipeline advanced.
  a_rise_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tready))
    else $error("result appeared without pipeline advance");

  // Configuration writes are never refused.
  a_cfg_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind radial_gradient_pixel_top rgp_checker u_rgp_checker (.*);
